@@ src/opr_pkg.sv @@
// ----------------------------------------------------------------------------
// opr_pkg
// Shared types, constants and helper functions of the ovoid point rotator.
// ----------------------------------------------------------------------------
package opr_pkg;

   localparam int unsigned SQRT_STAGES = 16;

   localparam logic [1:0] REG_LENGTH = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic [15:0] FACTOR_RESET = 16'd4096;

   localparam logic [2:0] PT_FRONT = 3'd1;
   localparam logic [2:0] PT_BACK  = 3'd2;
   localparam logic [2:0] PT_LEFT  = 3'd3;
   localparam logic [2:0] PT_RIGHT = 3'd4;
   localparam logic [2:0] PT_UP    = 3'd5;
   localparam logic [2:0] PT_DOWN  = 3'd6;

   localparam logic [2:0] POINT_LAST_SLOT = 3'd5;
   localparam logic [2:0] ITEM_GAP        = 3'd5;

   localparam logic signed [16:0] HALF_DEG = 17'sd23040;
   localparam logic signed [16:0] FULL_DEG = 17'sd46080;

   localparam logic [14:0] RECIP45_HI = 15'd23302;
   localparam logic [32:0] RECIP45_LO = 33'd6108397933;

   localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032875;
   localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

   typedef struct packed {
      logic              valid;
      logic              hvalid;
      logic              neg;
      logic [31:0]       rl;
      logic [31:0]       rw;
      logic [31:0]       rh;
      logic signed [33:0] cx;
      logic signed [33:0] cy;
      logic signed [33:0] cz;
      logic              over;
      logic [63:0]       rad;
      logic [35:0]       rem;
      logic [31:0]       root;
   } lane_type;

   function automatic logic [29:0] atan_turn(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:    v = 30'd536870912;
         5'd1:    v = 30'd316933406;
         5'd2:    v = 30'd167458907;
         5'd3:    v = 30'd85004756;
         5'd4:    v = 30'd42667331;
         5'd5:    v = 30'd21354465;
         5'd6:    v = 30'd10679838;
         5'd7:    v = 30'd5340245;
         5'd8:    v = 30'd2670163;
         5'd9:    v = 30'd1335087;
         5'd10:   v = 30'd667544;
         5'd11:   v = 30'd333772;
         5'd12:   v = 30'd166886;
         5'd13:   v = 30'd83443;
         5'd14:   v = 30'd41722;
         5'd15:   v = 30'd20861;
         5'd16:   v = 30'd10430;
         5'd17:   v = 30'd5215;
         5'd18:   v = 30'd2608;
         5'd19:   v = 30'd1304;
         5'd20:   v = 30'd652;
         5'd21:   v = 30'd326;
         5'd22:   v = 30'd163;
         5'd23:   v = 30'd81;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -34'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ src/opr_prep.sv @@
// ----------------------------------------------------------------------------
// opr_prep
// Front stages: reach products, heading wrap and angle conversion, squares
// and sum of squares, then the initial CORDIC / square root lane word.
// ----------------------------------------------------------------------------
module opr_prep import opr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [15:0] body_length,
   input  logic signed [15:0] heading_deg,
   input  logic        heading_valid,
   input  logic [15:0] length_factor,
   input  logic [15:0] width_factor,
   input  logic [15:0] height_factor,
   output lane_type    lane_next
);

   logic        s0_valid_ff;
   logic [15:0] s0_len_ff;
   logic signed [15:0] s0_head_ff;
   logic        s0_hv_ff;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_hv_ff;
   logic        s1_sgn_ff, s1_sgn_in;
   logic [14:0] s1_abs_ff, s1_abs_in;
   logic [9:0]  s1_qa_ff, s1_qa_in;
   logic [31:0] s1_rl_ff, s1_rw_ff, s1_rh_ff;
   logic [31:0] s1_rl_in, s1_rw_in, s1_rh_in;

   logic        s2_valid_ff;
   logic        s2_hv_ff, s2_sgn_ff;
   logic [9:0]  s2_qa_ff;
   logic [21:0] s2_f_ff, s2_f_in;
   logic [31:0] s2_rl_ff, s2_rw_ff, s2_rh_ff;
   logic [63:0] s2_ql_ff, s2_qw_ff, s2_qh_ff;
   logic [63:0] s2_ql_in, s2_qw_in, s2_qh_in;

   lane_type    lane_ff, lane_in;

   logic signed [16:0] wrap_a;
   logic signed [16:0] abs_a;
   logic [29:0] qa_prod;
   logic [14:0] ra_wide;
   logic [5:0]  ra;
   logic [38:0] f_prod;
   logic [31:0] mag;
   logic signed [33:0] z_raw;
   logic [65:0] sq_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
      s0_len_ff  <= body_length;
      s0_head_ff <= heading_deg;
      s0_hv_ff   <= heading_valid;
   end

   // wrap into (-180, 180] and split |a| / 45
   always_comb begin
      wrap_a = {s0_head_ff[15], s0_head_ff};
      if (wrap_a > HALF_DEG) begin
         wrap_a = wrap_a - FULL_DEG;
      end else if (wrap_a <= -HALF_DEG) begin
         wrap_a = wrap_a + FULL_DEG;
      end
      abs_a       = (wrap_a < 17'sd0) ? -wrap_a : wrap_a;
      s1_sgn_in   = wrap_a < 17'sd0;
      s1_abs_in   = abs_a[14:0];
      qa_prod     = s1_abs_in * RECIP45_HI;
      s1_qa_in    = qa_prod[29:20];
      s1_valid_in = s0_valid_ff;
      s1_rl_in    = s0_len_ff * length_factor;
      s1_rw_in    = s0_len_ff * width_factor;
      s1_rh_in    = s0_len_ff * height_factor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_hv_ff  <= s0_hv_ff;
      s1_sgn_ff <= s1_sgn_in;
      s1_abs_ff <= s1_abs_in;
      s1_qa_ff  <= s1_qa_in;
      s1_rl_ff  <= s1_rl_in;
      s1_rw_ff  <= s1_rw_in;
      s1_rh_ff  <= s1_rh_in;
   end

   // remainder part of a * 2^22 / 45, and squares of the reaches
   always_comb begin
      ra_wide  = s1_abs_ff - 15'(s1_qa_ff * 15'd45);
      ra       = ra_wide[5:0];
      f_prod   = {33'd0, ra} * {6'd0, RECIP45_LO};
      s2_f_in  = f_prod[37:16];
      s2_ql_in = s1_rl_ff * s1_rl_ff;
      s2_qw_in = s1_rw_ff * s1_rw_ff;
      s2_qh_in = s1_rh_ff * s1_rh_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_hv_ff  <= s1_hv_ff;
      s2_sgn_ff <= s1_sgn_ff;
      s2_qa_ff  <= s1_qa_ff;
      s2_f_ff   <= s2_f_in;
      s2_rl_ff  <= s1_rl_ff;
      s2_rw_ff  <= s1_rw_ff;
      s2_rh_ff  <= s1_rh_ff;
      s2_ql_ff  <= s2_ql_in;
      s2_qw_ff  <= s2_qw_in;
      s2_qh_ff  <= s2_qh_in;
   end

   // binary angle, quadrant fold, lane start word
   always_comb begin
      mag   = {s2_qa_ff, 22'd0} + {10'd0, s2_f_ff};
      z_raw = s2_sgn_ff ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      sq_sum = {2'b00, s2_ql_ff} + {2'b00, s2_qw_ff} + {2'b00, s2_qh_ff};
      lane_in        = '0;
      lane_in.valid  = s2_valid_ff;
      lane_in.hvalid = s2_hv_ff;
      lane_in.rl     = s2_rl_ff;
      lane_in.rw     = s2_rw_ff;
      lane_in.rh     = s2_rh_ff;
      lane_in.cx     = CORDIC_GAIN;
      lane_in.cy     = 34'sd0;
      lane_in.cz     = z_raw;
      lane_in.neg    = 1'b0;
      if (z_raw > QUARTER_TURN) begin
         lane_in.cz  = z_raw - HALF_TURN;
         lane_in.neg = 1'b1;
      end else if (z_raw < -QUARTER_TURN) begin
         lane_in.cz  = z_raw + HALF_TURN;
         lane_in.neg = 1'b1;
      end
      lane_in.over = sq_sum[65:64] != 2'b00;
      lane_in.rad  = sq_sum[63:0];
      lane_in.rem  = 36'd0;
      lane_in.root = 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign lane_next = lane_ff;

endmodule

@@ src/opr_lane_stage.sv @@
// ----------------------------------------------------------------------------
// opr_lane_stage
// One pipeline stage: one CORDIC rotation step while STAGE_INDEX < CORDIC_STAGES,
// and two square root digits while STAGE_INDEX < SQRT_STAGES.
module opr_lane_stage import opr_pkg::*; #(
   parameter int unsigned STAGE_INDEX   = 0,
   parameter int unsigned CORDIC_STAGES = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  lane_type lane_prev,
   output lane_type lane_next
);

   lane_type lane_ff, lane_in;

   logic signed [33:0] dx, dy;
   logic signed [33:0] step_angle;
   logic [35:0] trial_rem, trial_sub;

   always_comb begin
      lane_in    = lane_prev;
      dx         = lane_prev.cy >>> STAGE_INDEX;
      dy         = lane_prev.cx >>> STAGE_INDEX;
      step_angle = $signed({4'd0, atan_turn(5'(STAGE_INDEX))});
      trial_rem  = 36'd0;
      trial_sub  = 36'd0;
      if (STAGE_INDEX < CORDIC_STAGES) begin
         if (lane_prev.cz >= 34'sd0) begin
            lane_in.cx = lane_prev.cx - dx;
            lane_in.cy = lane_prev.cy + dy;
            lane_in.cz = lane_prev.cz - step_angle;
         end else begin
            lane_in.cx = lane_prev.cx + dx;
            lane_in.cy = lane_prev.cy - dy;
            lane_in.cz = lane_prev.cz + step_angle;
         end
      end
      if (STAGE_INDEX < SQRT_STAGES) begin
         for (int j = 0; j < 2; j++) begin
            trial_rem = {lane_in.rem[33:0], lane_in.rad[63:62]};
            trial_sub = {2'b00, lane_in.root, 2'b01};
            lane_in.rad = {lane_in.rad[61:0], 2'b00};
            if (trial_rem >= trial_sub) begin
               lane_in.rem  = trial_rem - trial_sub;
               lane_in.root = {lane_in.root[30:0], 1'b1};
            end else begin
               lane_in.rem  = trial_rem;
               lane_in.root = {lane_in.root[30:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign lane_next = lane_ff;

endmodule

@@ src/opr_emit.sv @@
// ----------------------------------------------------------------------------
// opr_emit
// Rotation products, rounding and saturation into a six point buffer, then
// one point per cycle onto the result port.
// ----------------------------------------------------------------------------
module opr_emit import opr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  lane_type    lane_last,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_point_index,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_z,
   output logic [31:0] rsp_diagonal_length,
   output logic        rsp_last_point
);

   function automatic logic signed [31:0] round_q30(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd536870912;
      return sat32($signed(t[63:30]));
   endfunction

   logic        e1_valid_ff;
   logic        e1_hv_ff;
   logic [31:0] e1_rl_ff, e1_rw_ff, e1_rh_ff;
   logic [31:0] e1_diag_ff, e1_diag_in;
   logic signed [63:0] e1_lc_ff, e1_ls_ff, e1_wc_ff, e1_ws_ff;
   logic signed [63:0] e1_lc_in, e1_ls_in, e1_wc_in, e1_ws_in;

   logic signed [31:0] cos_v, sin_v;
   logic signed [32:0] rl_s, rw_s;

   logic signed [31:0] bx_ff [6];
   logic signed [31:0] by_ff [6];
   logic signed [31:0] bz_ff [6];
   logic signed [31:0] bx_in [6];
   logic signed [31:0] by_in [6];
   logic signed [31:0] bz_in [6];
   logic [31:0] bdiag_ff;

   logic        active_ff, active_in;
   logic [2:0]  cnt_ff, cnt_in;

   logic        out_strobe_ff;
   logic [2:0]  out_index_ff;
   logic signed [31:0] out_x_ff, out_y_ff, out_z_ff;
   logic [31:0] out_diag_ff;
   logic        out_last_ff;

   always_comb begin
      cos_v = lane_last.neg ? 32'(-lane_last.cx) : lane_last.cx[31:0];
      sin_v = lane_last.neg ? 32'(-lane_last.cy) : lane_last.cy[31:0];
      rl_s  = $signed({1'b0, lane_last.rl});
      rw_s  = $signed({1'b0, lane_last.rw});
      e1_lc_in   = 64'(rl_s) * 64'(cos_v);
      e1_ls_in   = 64'(rl_s) * 64'(sin_v);
      e1_wc_in   = 64'(rw_s) * 64'(cos_v);
      e1_ws_in   = 64'(rw_s) * 64'(sin_v);
      e1_diag_in = lane_last.over ? 32'hFFFFFFFF : lane_last.root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else begin
         e1_valid_ff <= lane_last.valid;
      end
      e1_hv_ff   <= lane_last.hvalid;
      e1_rl_ff   <= lane_last.rl;
      e1_rw_ff   <= lane_last.rw;
      e1_rh_ff   <= lane_last.rh;
      e1_diag_ff <= e1_diag_in;
      e1_lc_ff   <= e1_lc_in;
      e1_ls_ff   <= e1_ls_in;
      e1_wc_ff   <= e1_wc_in;
      e1_ws_ff   <= e1_ws_in;
   end

   // point coordinates, slot k-1 holds point k
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         bx_in[k] = 32'sd0;
         by_in[k] = 32'sd0;
         bz_in[k] = 32'sd0;
      end
      bz_in[PT_UP - 3'd1]   = sat32($signed({2'b00, e1_rh_ff}));
      bz_in[PT_DOWN - 3'd1] = sat32(-$signed({2'b00, e1_rh_ff}));
      if (e1_hv_ff) begin
         bx_in[PT_FRONT - 3'd1] = round_q30(e1_lc_ff);
         by_in[PT_FRONT - 3'd1] = round_q30(e1_ls_ff);
         bx_in[PT_BACK - 3'd1]  = round_q30(-e1_lc_ff);
         by_in[PT_BACK - 3'd1]  = round_q30(-e1_ls_ff);
         bx_in[PT_LEFT - 3'd1]  = round_q30(-e1_ws_ff);
         by_in[PT_LEFT - 3'd1]  = round_q30(e1_wc_ff);
         bx_in[PT_RIGHT - 3'd1] = round_q30(e1_ws_ff);
         by_in[PT_RIGHT - 3'd1] = round_q30(-e1_wc_ff);
      end else begin
         bx_in[PT_FRONT - 3'd1] = sat32($signed({2'b00, e1_rl_ff}));
         bx_in[PT_BACK - 3'd1]  = sat32(-$signed({2'b00, e1_rl_ff}));
         by_in[PT_LEFT - 3'd1]  = sat32($signed({2'b00, e1_rw_ff}));
         by_in[PT_RIGHT - 3'd1] = sat32(-$signed({2'b00, e1_rw_ff}));
      end
   end

   always_ff @(posedge clock) begin
      if (e1_valid_ff) begin
         bx_ff    <= bx_in;
         by_ff    <= by_in;
         bz_ff    <= bz_in;
         bdiag_ff <= e1_diag_ff;
      end
   end

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      if (active_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == POINT_LAST_SLOT) begin
            active_in = 1'b0;
         end
      end
      if (e1_valid_ff) begin
         active_in = 1'b1;
         cnt_in    = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         cnt_ff        <= 3'd0;
         out_strobe_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         cnt_ff        <= cnt_in;
         out_strobe_ff <= active_ff;
      end
      out_index_ff <= cnt_ff + 3'd1;
      out_x_ff     <= bx_ff[cnt_ff];
      out_y_ff     <= by_ff[cnt_ff];
      out_z_ff     <= bz_ff[cnt_ff];
      out_diag_ff  <= bdiag_ff;
      out_last_ff  <= cnt_ff == POINT_LAST_SLOT;
   end

   assign rsp_strobe          = out_strobe_ff;
   assign rsp_point_index     = out_index_ff;
   assign rsp_point_x         = out_x_ff;
   assign rsp_point_y         = out_y_ff;
   assign rsp_point_z         = out_z_ff;
   assign rsp_diagonal_length = out_diag_ff;
   assign rsp_last_point      = out_last_ff;

endmodule

@@ src/ovoid_point_rotator.sv @@
// ----------------------------------------------------------------------------
// ovoid_point_rotator
// Six ovoid points around a body, horizontal points rotated by heading when req_heading_valid is high.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// while the gap counter runs down from ITEM_GAP, so the spacing of requests is
// set by the single result port that carries six points per request. The six
// points come out back to back, each marked by rsp_strobe, after the prep
// stages, the lane chain and the emit registers; the lane chain is as deep as
// the longer of the CORDIC chain and the 32-digit square root.
// The receiver cannot stall. Register writes are taken at once (csr_ready is
// always high) and belong between requests.
module ovoid_point_rotator import opr_pkg::*; #(
   parameter int unsigned CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_body_length,
   input  logic signed [15:0] req_heading_deg,
   input  logic        req_heading_valid,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_point_index,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_z,
   output logic [31:0] rsp_diagonal_length,
   output logic        rsp_last_point,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int unsigned LANE_STAGES =
      (CORDIC_STAGES > SQRT_STAGES) ? CORDIC_STAGES : SQRT_STAGES;

   logic [15:0] length_factor_ff, width_factor_ff, height_factor_ff;
   logic [2:0]  gap_ff, gap_in;
   logic        accept;

   lane_type chain [LANE_STAGES + 1];

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign busy      = gap_ff != 3'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_factor_ff <= FACTOR_RESET;
         width_factor_ff  <= FACTOR_RESET;
         height_factor_ff <= FACTOR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LENGTH: length_factor_ff <= csr_data;
            REG_WIDTH:  width_factor_ff  <= csr_data;
            REG_HEIGHT: height_factor_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      gap_in = gap_ff;
      if (accept) begin
         gap_in = ITEM_GAP;
      end else if (gap_ff != 3'd0) begin
         gap_in = gap_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= 3'd0;
      end else begin
         gap_ff <= gap_in;
      end
   end

   opr_prep u_prep (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .body_length   (req_body_length),
      .heading_deg   (req_heading_deg),
      .heading_valid (req_heading_valid),
      .length_factor (length_factor_ff),
      .width_factor  (width_factor_ff),
      .height_factor (height_factor_ff),
      .lane_next     (chain[0])
   );

   for (genvar k = 0; k < LANE_STAGES; k++) begin : g_lane
      opr_lane_stage #(
         .STAGE_INDEX   (k),
         .CORDIC_STAGES (CORDIC_STAGES)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .lane_prev (chain[k]),
         .lane_next (chain[k + 1])
      );
   end

   opr_emit u_emit (
      .clock               (clock),
      .reset               (reset),
      .lane_last           (chain[LANE_STAGES]),
      .rsp_strobe          (rsp_strobe),
      .rsp_point_index     (rsp_point_index),
      .rsp_point_x         (rsp_point_x),
      .rsp_point_y         (rsp_point_y),
      .rsp_point_z         (rsp_point_z),
      .rsp_diagonal_length (rsp_diagonal_length),
      .rsp_last_point      (rsp_last_point)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after request");

   a_last_is_down: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_point) |-> (rsp_point_index == PT_DOWN))
      else $error("last point flag on wrong point");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_point) |=>
         (rsp_strobe && rsp_point_index == $past(rsp_point_index) + 3'd1))
      else $error("point burst broken");
`endif

endmodule

@@ tb/ovoid_point_rotator_checker.sv @@
// ----------------------------------------------------------------------------
// ovoid_point_rotator_checker
// Watches the request, result and register channels of the ovoid point
// rotator, predicts the six points of every accepted request and compares
// each result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ovoid_point_rotator_checker import opr_pkg::*; #(
   parameter int unsigned CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [15:0]        req_body_length,
   input  logic signed [15:0] req_heading_deg,
   input  logic               req_heading_valid,
   input  logic               rsp_strobe,
   input  logic [2:0]         rsp_point_index,
   input  logic signed [31:0] rsp_point_x,
   input  logic signed [31:0] rsp_point_y,
   input  logic signed [31:0] rsp_point_z,
   input  logic [31:0]        rsp_diagonal_length,
   input  logic               rsp_last_point,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data,
   output int                 fail_count,
   output int                 pending
);

   typedef struct {
      logic [2:0]  index;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] diag;
      logic        last;
   } point_type;

   point_type   expected_points[$];
   logic [15:0] length_gain;
   logic [15:0] width_gain;
   logic [15:0] height_gain;

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [31:0] root64(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res[31:0];
   endfunction

   function automatic longint turn_angle(input int unsigned i);
      case (i)
         0: return 536870912;   1: return 316933406;   2: return 167458907;
         3: return 85004756;    4: return 42667331;    5: return 21354465;
         6: return 10679838;    7: return 5340245;     8: return 2670163;
         9: return 1335087;     10: return 667544;     11: return 333772;
         12: return 166886;     13: return 83443;      14: return 41722;
         15: return 20861;      16: return 10430;      17: return 5215;
         18: return 2608;       19: return 1304;       20: return 652;
         21: return 326;        22: return 163;        23: return 81;
         default: return 0;
      endcase
   endfunction

   task automatic heading_cos_sin(input logic signed [15:0] hd,
                                  output longint c, output longint s);
      int     a;
      longint z;
      longint x;
      longint y;
      longint dx;
      longint dy;
      logic   flip;
      a    = int'(hd) % 46080;
      x    = 652032875;
      y    = 0;
      flip = 1'b0;
      if (a > 23040) a -= 46080;
      if (a <= -23040) a += 46080;
      z = (longint'(a) * 64'sd4194304) / 64'sd45;
      if (z > 64'sd1073741824) begin
         z    = z - 64'sd2147483648;
         flip = 1'b1;
      end else if (z < -64'sd1073741824) begin
         z    = z + 64'sd2147483648;
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - turn_angle(i);
         end else begin
            x = x + dx; y = y - dy; z = z + turn_angle(i);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint rotate_term(input longint r, input longint t);
      return clamp32((r * t + (64'sd1 << 29)) >>> 30);
   endfunction

   task automatic predict_points(input logic [15:0] len,
                                 input logic signed [15:0] hd,
                                 input logic hv);
      longint    rl;
      longint    rw;
      longint    rh;
      longint    c;
      longint    s;
      longint    px[7];
      longint    py[7];
      longint    pz[7];
      logic [65:0] sq;
      logic [31:0] diag;
      point_type   p;
      rl = longint'(len) * longint'(length_gain);
      rw = longint'(len) * longint'(width_gain);
      rh = longint'(len) * longint'(height_gain);
      sq = 66'(rl) * 66'(rl) + 66'(rw) * 66'(rw) + 66'(rh) * 66'(rh);
      diag = (sq[65:64] != 0) ? 32'hFFFFFFFF : root64(sq[63:0]);
      for (int k = 0; k < 7; k++) begin
         px[k] = 0; py[k] = 0; pz[k] = 0;
      end
      px[PT_FRONT] = clamp32(rl);  px[PT_BACK] = clamp32(-rl);
      py[PT_LEFT]  = clamp32(rw);  py[PT_RIGHT] = clamp32(-rw);
      pz[PT_UP]    = clamp32(rh);  pz[PT_DOWN] = clamp32(-rh);
      if (hv) begin
         heading_cos_sin(hd, c, s);
         px[PT_FRONT] = rotate_term(rl, c);   py[PT_FRONT] = rotate_term(rl, s);
         px[PT_BACK]  = rotate_term(rl, -c);  py[PT_BACK]  = rotate_term(rl, -s);
         px[PT_LEFT]  = rotate_term(rw, -s);  py[PT_LEFT]  = rotate_term(rw, c);
         px[PT_RIGHT] = rotate_term(rw, s);   py[PT_RIGHT] = rotate_term(rw, -c);
      end
      for (int k = PT_FRONT; k <= PT_DOWN; k++) begin
         p.index = 3'(k);
         p.x     = px[k][31:0];
         p.y     = py[k][31:0];
         p.z     = pz[k][31:0];
         p.diag  = diag;
         p.last  = (k == PT_DOWN);
         expected_points.push_back(p);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      point_type p;
      if (reset) begin
         length_gain = FACTOR_RESET;
         width_gain  = FACTOR_RESET;
         height_gain = FACTOR_RESET;
         fail_count  = 0;
         expected_points.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected point %0d, expected none", $time,
                        rsp_point_index);
               fail_count++;
            end else begin
               p = expected_points.pop_front();
               compare_field("point_index", 32'(p.index), 32'(rsp_point_index));
               compare_field("point_x", p.x, rsp_point_x);
               compare_field("point_y", p.y, rsp_point_y);
               compare_field("point_z", p.z, rsp_point_z);
               compare_field("diagonal_length", p.diag, rsp_diagonal_length);
               compare_field("last_point", 32'(p.last), 32'(rsp_last_point));
            end
         end
         if (start && !busy) begin
            predict_points(req_body_length, req_heading_deg, req_heading_valid);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_LENGTH: length_gain = csr_data;
               REG_WIDTH:  width_gain  = csr_data;
               REG_HEIGHT: height_gain = csr_data;
               default: ;
            endcase
         end
      end
      pending = expected_points.size();
   end

endmodule

@@ tb/ovoid_point_rotator_tb.sv @@
// ----------------------------------------------------------------------------
// ovoid_point_rotator_tb
// Drives directed and random requests into the ovoid point rotator under
// several factor settings and sender idle rates; a checker beside the block
// predicts and compares every point.
// ----------------------------------------------------------------------------
module ovoid_point_rotator_tb;
   import opr_pkg::*;

   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam int         DRAIN_CYCLES = 40;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [15:0]        req_body_length;
   logic signed [15:0] req_heading_deg;
   logic               req_heading_valid;
   logic               rsp_strobe;
   logic [2:0]         rsp_point_index;
   logic signed [31:0] rsp_point_x;
   logic signed [31:0] rsp_point_y;
   logic signed [31:0] rsp_point_z;
   logic [31:0]        rsp_diagonal_length;
   logic               rsp_last_point;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [15:0]        csr_data;
   int                 fail_count;
   int                 pending;
   int                 idle_pct;
   int                 request_total;
   int                 setting_total;

   ovoid_point_rotator i_dut (.*);

   ovoid_point_rotator_checker i_checker (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_request(input logic [15:0] len, input logic signed [15:0] hd,
                               input logic hv);
      logic taken;
      start             <= 1'b1;
      req_body_length   <= len;
      req_heading_deg   <= hd;
      req_heading_valid <= hv;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
      request_total++;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      logic taken;
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic set_factors(input logic [15:0] fl, input logic [15:0] fw,
                              input logic [15:0] fh);
      write_reg(REG_LENGTH, fl);
      write_reg(REG_WIDTH, fw);
      write_reg(REG_HEIGHT, fh);
      setting_total++;
   endtask

   function automatic logic [15:0] pick_factor();
      case ($urandom_range(0, 4))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 8192));
         2: return 16'hFFFF;
         default: return 16'($urandom_range(2048, 6144));
      endcase
   endfunction

   task automatic random_requests(input int count);
      logic [15:0]        len;
      logic signed [15:0] hd;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: len = 16'($urandom);
            1: len = 16'($urandom_range(0, 1023));
            default: len = 16'($urandom_range(0, 16383));
         endcase
         if ($urandom_range(0, 4) == 0) hd = 16'($urandom);
         else hd = 16'(int'($urandom_range(0, 46080)) - 23040);
         send_request(len, hd, $urandom_range(0, 3) != 0);
      end
   endtask

   initial begin
      start             = 1'b0;
      req_body_length   = '0;
      req_heading_deg   = '0;
      req_heading_valid = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = REG_LENGTH;
      csr_data          = '0;
      request_total     = 0;
      setting_total     = 0;
      idle_pct          = 0;
      reset             = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, cardinal headings, wrap of out-of-range headings
      send_request(16'd0, 16'sd0, 1'b1);
      send_request(16'hFFFF, 16'sd0, 1'b0);
      send_request(16'd256, 16'sd0, 1'b1);
      send_request(16'd256, 16'sd11520, 1'b1);
      send_request(16'd256, -16'sd11520, 1'b1);
      send_request(16'd256, 16'sd23040, 1'b1);
      send_request(16'd256, -16'sd23040, 1'b1);
      send_request(16'd300, 16'sd11521, 1'b1);
      send_request(16'd300, -16'sd11521, 1'b1);
      send_request(16'd1000, 16'sd23041, 1'b1);
      send_request(16'd1000, 16'sh7FFF, 1'b1);
      send_request(16'd1000, 16'sh8000, 1'b1);
      send_request(16'd1000, 16'sd1, 1'b1);
      send_request(16'd1000, -16'sd1, 1'b1);
      send_request(16'hFFFF, 16'sd5760, 1'b1);
      send_request(16'd1, 16'sd17280, 1'b0);
      write_reg(REG_SPARE, 16'h1234);
      set_factors(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(16'hFFFF, 16'sd0, 1'b0);
      send_request(16'hFFFF, 16'sd5760, 1'b1);
      send_request(16'h8000, -16'sd17280, 1'b1);
      set_factors(16'd0, 16'd0, 16'd0);
      send_request(16'hFFFF, 16'sd3000, 1'b1);
      send_request(16'd500, 16'sd0, 1'b0);
      set_factors(16'd0, 16'hFFFF, 16'd4096);
      send_request(16'h1234, 16'sd7000, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 33 : (phase == 1) ? 45 : 0;
         for (int s = 0; s < 2; s++) begin
            set_factors(pick_factor(), pick_factor(), pick_factor());
            random_requests(55);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d requests over %0d factor settings", request_total,
               setting_total);
      $display("sender idle rates 33, 45 and 0 percent, %0d failures", fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/opr_pkg.sv
src/opr_prep.sv
src/opr_lane_stage.sv
src/opr_emit.sv
src/ovoid_point_rotator.sv
tb/ovoid_point_rotator_checker.sv
tb/ovoid_point_rotator_tb.sv
